FILE: design/snpdd_pkg.sv
package snpdd_pkg;

    localparam int POOL_DEPTH        = 1024;
    localparam int WORDS_PER_PATTERN = 4;
    localparam int WORD_BITS         = 64;

    localparam int POOL_AW    = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int WPP_W      = (WORDS_PER_PATTERN > 1) ? $clog2(WORDS_PER_PATTERN) : 1;
    localparam int POOL_WORDS = POOL_DEPTH * WORDS_PER_PATTERN;
    localparam int PW_AW      = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;

    localparam int SAMPLE_W = 9;
    localparam int LIMIT_W  = 11;
    localparam int ALLELE_W = 9;
    localparam int COUNT_W  = 16;
    localparam int IDX_W    = 10;
    localparam int META_W   = COUNT_W + ALLELE_W;
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int SAMPLE_RESET = 256;
    localparam int LIMIT_RESET  = 1024;

    // register indexes
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_POOL_LIMIT   = 1'b1;

    // item kinds
    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [WORD_BITS-1:0]  sample_word;
        logic                  last_word;
        logic [ALLELE_W-1:0]   derived_count;
    } snpdd_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]    pattern_index;
        logic                new_pattern;
        logic                inverted_match;
        logic [COUNT_W-1:0]  pattern_count;
        logic                pool_full;
        logic                overflow;
    } snpdd_out_t;

endpackage

FILE: design/snpdd_ram.sv
module snpdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/snp_pattern_dedup_pool_unit.sv
// Non-last words and clear items are taken one per cycle.
// A last word scans the pool one stored 64-bit word per cycle. A complement hit is
// known only when the scan ends; an exact hit on entry j stops the scan there. Both hits
// read and then write the entry's count before the result is loaded, a new entry first
// appends its words and a drop loads its result straight after the scan. A full output
// adds its wait, and the next word is taken in the cycle after the result is loaded.
module snp_pattern_dedup_pool_unit
    import snpdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               site_valid,
    output logic               site_ready,
    input  snpdd_in_t          site,
    output logic               result_valid,
    input  logic               result_ready,
    output snpdd_out_t         result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COUNT_RD,
        S_COUNT_WR,
        S_APPEND,
        S_OUT
    } state_t;

    localparam logic [WPP_W-1:0] LAST_K = WPP_W'(WORDS_PER_PATTERN - 1);

    function automatic logic [WORD_BITS-1:0] used_mask(input logic [WPP_W-1:0] k,
                                                       input logic [SAMPLE_W-1:0] sc);
        int samples;
        int lo;
        int diff;
        samples = int'(sc);
        if (samples > WORD_BITS * WORDS_PER_PATTERN)
        begin
            samples = WORD_BITS * WORDS_PER_PATTERN;
        end
        lo = int'(k) * WORD_BITS;
        if (lo >= samples)
        begin
            return '0;
        end
        diff = samples - lo;
        if (diff >= WORD_BITS)
        begin
            return '1;
        end
        return (WORD_BITS'(1) << diff) - WORD_BITS'(1);
    endfunction

    function automatic logic full_flag(input logic [CNT_W-1:0] n,
                                       input logic [LIMIT_W-1:0] limit);
        return (32'(n) >= 32'(limit)) || (32'(n) >= POOL_DEPTH);
    endfunction

    function automatic logic [IDX_W-1:0] to_index(input logic [POOL_AW-1:0] i);
        logic [31:0] t;
        t = 32'(i);
        return t[IDX_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      entry_count_reg, entry_count_next;
    logic [WPP_W-1:0]      word_pos_reg, word_pos_next;
    logic [WORD_BITS-1:0]  incoming_reg [WORDS_PER_PATTERN];
    logic [WORD_BITS-1:0]  incoming_next [WORDS_PER_PATTERN];
    logic [ALLELE_W-1:0]   derived_reg, derived_next;
    logic [PW_AW:0]        rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]      iss_e_reg, iss_e_next;
    logic [WPP_W-1:0]      iss_k_reg, iss_k_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [WPP_W-1:0]      cmp_k_reg, cmp_k_next;
    logic [POOL_AW-1:0]    cmp_e_reg, cmp_e_next;
    logic                  eq_run_reg, eq_run_next;
    logic                  inv_run_reg, inv_run_next;
    logic                  inv_found_reg, inv_found_next;
    logic [POOL_AW-1:0]    inv_idx_reg, inv_idx_next;
    logic [POOL_AW-1:0]    idx_reg, idx_next;
    logic                  inv_hit_reg, inv_hit_next;
    snpdd_out_t            res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    snpdd_out_t            out_data_reg, out_data_next;
    logic [SAMPLE_W-1:0]   sample_count_reg, sample_count_next;
    logic [LIMIT_W-1:0]    pool_limit_reg, pool_limit_next;

    logic                  pool_we;
    logic [WORD_BITS-1:0]  pool_rdata;
    logic                  meta_we;
    logic [META_W-1:0]     meta_wdata;
    logic [META_W-1:0]     meta_rdata;

    logic [WPP_W-1:0]      mask_k;
    logic [WORD_BITS-1:0]  word_mask;
    logic [WORD_BITS-1:0]  site_word;
    logic                  eq_acc;
    logic                  inv_acc;
    logic                  issue;
    logic                  cfg_write;
    logic [COUNT_W-1:0]    old_count;
    logic [COUNT_W-1:0]    new_count;

    snpdd_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (POOL_WORDS)
    ) u_pool_ram (
        .clk   (clk),
        .we    (pool_we),
        .waddr (rd_addr_reg[PW_AW-1:0]),
        .wdata (site_word),
        .raddr (rd_addr_reg[PW_AW-1:0]),
        .rdata (pool_rdata)
    );

    snpdd_ram #(
        .WIDTH (META_W),
        .DEPTH (POOL_DEPTH)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (idx_reg),
        .wdata (meta_wdata),
        .raddr (idx_reg),
        .rdata (meta_rdata)
    );

    assign site_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_SAMPLE_COUNT: prdata = PDATA_W'(sample_count_reg);
            REG_POOL_LIMIT:   prdata = PDATA_W'(pool_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // masked site word for the word being compared or written
    assign mask_k    = (state_reg == S_APPEND) ? iss_k_reg : cmp_k_reg;
    assign word_mask = used_mask(mask_k, sample_count_reg);
    assign site_word = incoming_reg[mask_k] & word_mask;
    assign eq_acc    = eq_run_reg && (pool_rdata == site_word);
    assign inv_acc   = inv_run_reg && (pool_rdata == (site_word ^ word_mask));
    assign issue     = (iss_e_reg < entry_count_reg);
    assign old_count = meta_rdata[META_W-1:ALLELE_W];
    assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        entry_count_next  = entry_count_reg;
        word_pos_next     = word_pos_reg;
        incoming_next     = incoming_reg;
        derived_next      = derived_reg;
        rd_addr_next      = rd_addr_reg;
        iss_e_next        = iss_e_reg;
        iss_k_next        = iss_k_reg;
        cmp_valid_next    = cmp_valid_reg;
        cmp_k_next        = cmp_k_reg;
        cmp_e_next        = cmp_e_reg;
        eq_run_next       = eq_run_reg;
        inv_run_next      = inv_run_reg;
        inv_found_next    = inv_found_reg;
        inv_idx_next      = inv_idx_reg;
        idx_next          = idx_reg;
        inv_hit_next      = inv_hit_reg;
        res_next          = res_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && !result_ready;
        sample_count_next = sample_count_reg;
        pool_limit_next   = pool_limit_reg;
        pool_we           = 1'b0;
        meta_we           = 1'b0;
        meta_wdata        = {new_count, meta_rdata[ALLELE_W-1:0]};

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SAMPLE_COUNT: sample_count_next = pwdata[SAMPLE_W-1:0];
                REG_POOL_LIMIT:   pool_limit_next   = pwdata[LIMIT_W-1:0];
                default:          sample_count_next = sample_count_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (site_valid)
                begin
                    if (site.kind == KIND_CLEAR)
                    begin
                        entry_count_next = '0;
                        word_pos_next    = '0;
                        for (int i = 0; i < WORDS_PER_PATTERN; i++)
                        begin
                            incoming_next[i] = '0;
                        end
                    end
                    else
                    begin
                        incoming_next[word_pos_reg] = site.sample_word;
                        if (site.last_word)
                        begin
                            derived_next   = site.derived_count;
                            rd_addr_next   = '0;
                            iss_e_next     = '0;
                            iss_k_next     = '0;
                            cmp_valid_next = 1'b0;
                            eq_run_next    = 1'b1;
                            inv_run_next   = 1'b1;
                            inv_found_next = 1'b0;
                            state_next     = S_SEARCH;
                        end
                        else if (word_pos_reg != LAST_K)
                        begin
                            word_pos_next = word_pos_reg + WPP_W'(1);
                        end
                    end
                end
            end

            S_SEARCH:
            begin
                if (cmp_valid_reg && cmp_k_reg == LAST_K && eq_acc)
                begin
                    // exact hit wins over any complement hit; drop the read in flight
                    idx_next       = cmp_e_reg;
                    inv_hit_next   = 1'b0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_COUNT_RD;
                end
                else
                begin
                    if (cmp_valid_reg)
                    begin
                        if (cmp_k_reg == LAST_K)
                        begin
                            if (inv_acc && !inv_found_reg)
                            begin
                                inv_found_next = 1'b1;
                                inv_idx_next   = cmp_e_reg;
                            end
                            eq_run_next  = 1'b1;
                            inv_run_next = 1'b1;
                        end
                        else
                        begin
                            eq_run_next  = eq_acc;
                            inv_run_next = inv_acc;
                        end
                    end

                    if (issue)
                    begin
                        cmp_valid_next = 1'b1;
                        cmp_k_next     = iss_k_reg;
                        cmp_e_next     = iss_e_reg[POOL_AW-1:0];
                        rd_addr_next   = rd_addr_reg + (PW_AW + 1)'(1);
                        if (iss_k_reg == LAST_K)
                        begin
                            iss_k_next = '0;
                            iss_e_next = iss_e_reg + CNT_W'(1);
                        end
                        else
                        begin
                            iss_k_next = iss_k_reg + WPP_W'(1);
                        end
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                        if (!cmp_valid_reg)
                        begin
                            // scan done with no exact hit
                            priority if (inv_found_reg)
                            begin
                                idx_next     = inv_idx_reg;
                                inv_hit_next = 1'b1;
                                state_next   = S_COUNT_RD;
                            end
                            else if (full_flag(entry_count_reg, pool_limit_reg))
                            begin
                                res_next           = '0;
                                res_next.pool_full = 1'b1;
                                res_next.overflow  = 1'b1;
                                state_next         = S_OUT;
                            end
                            else
                            begin
                                idx_next   = entry_count_reg[POOL_AW-1:0];
                                iss_k_next = '0;
                                state_next = S_APPEND;
                            end
                        end
                    end
                end
            end

            S_COUNT_RD:
            begin
                state_next = S_COUNT_WR;
            end

            S_COUNT_WR:
            begin
                meta_we                 = 1'b1;
                res_next.pattern_index  = to_index(idx_reg);
                res_next.new_pattern    = 1'b0;
                res_next.inverted_match = inv_hit_reg;
                res_next.pattern_count  = new_count;
                res_next.pool_full      = full_flag(entry_count_reg, pool_limit_reg);
                res_next.overflow       = 1'b0;
                state_next              = S_OUT;
            end

            S_APPEND:
            begin
                // rd_addr already points past the last stored word
                pool_we      = 1'b1;
                rd_addr_next = rd_addr_reg + (PW_AW + 1)'(1);
                if (iss_k_reg == '0)
                begin
                    meta_we    = 1'b1;
                    meta_wdata = {COUNT_W'(1), derived_reg};
                end
                if (iss_k_reg == LAST_K)
                begin
                    entry_count_next        = entry_count_reg + CNT_W'(1);
                    res_next.pattern_index  = to_index(idx_reg);
                    res_next.new_pattern    = 1'b1;
                    res_next.inverted_match = 1'b0;
                    res_next.pattern_count  = COUNT_W'(1);
                    res_next.pool_full      = full_flag(entry_count_reg + CNT_W'(1),
                                                        pool_limit_reg);
                    res_next.overflow       = 1'b0;
                    state_next              = S_OUT;
                end
                else
                begin
                    iss_k_next = iss_k_reg + WPP_W'(1);
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    word_pos_next  = '0;
                    for (int i = 0; i < WORDS_PER_PATTERN; i++)
                    begin
                        incoming_next[i] = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            entry_count_reg  <= '0;
            word_pos_reg     <= '0;
            for (int i = 0; i < WORDS_PER_PATTERN; i++)
            begin
                incoming_reg[i] <= '0;
            end
            derived_reg      <= '0;
            rd_addr_reg      <= '0;
            iss_e_reg        <= '0;
            iss_k_reg        <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_k_reg        <= '0;
            cmp_e_reg        <= '0;
            eq_run_reg       <= 1'b1;
            inv_run_reg      <= 1'b1;
            inv_found_reg    <= 1'b0;
            inv_idx_reg      <= '0;
            idx_reg          <= '0;
            inv_hit_reg      <= 1'b0;
            res_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            sample_count_reg <= SAMPLE_W'(SAMPLE_RESET);
            pool_limit_reg   <= LIMIT_W'(LIMIT_RESET);
        end
        else
        begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            word_pos_reg     <= word_pos_next;
            incoming_reg     <= incoming_next;
            derived_reg      <= derived_next;
            rd_addr_reg      <= rd_addr_next;
            iss_e_reg        <= iss_e_next;
            iss_k_reg        <= iss_k_next;
            cmp_valid_reg    <= cmp_valid_next;
            cmp_k_reg        <= cmp_k_next;
            cmp_e_reg        <= cmp_e_next;
            eq_run_reg       <= eq_run_next;
            inv_run_reg      <= inv_run_next;
            inv_found_reg    <= inv_found_next;
            inv_idx_reg      <= inv_idx_next;
            idx_reg          <= idx_next;
            inv_hit_reg      <= inv_hit_next;
            res_reg          <= res_next;
            out_valid_reg    <= out_valid_next;
            out_data_reg     <= out_data_next;
            sample_count_reg <= sample_count_next;
            pool_limit_reg   <= pool_limit_next;
        end
    end

endmodule
